// ===== hdl/dfc_pkg.sv =====
// Shared types for the distinct-frequency checker.
// Command and status bundles between the controller and the datapath.
package dfc_pkg;

  typedef struct packed {
    logic load_en;     // take input beats, histogram update path live
    logic walk_start;  // arm the distinct flag before a walk
    logic walk_rd;     // read histogram at the sweep counter
    logic clear_wr;    // write zeros at the sweep counter
    logic cnt_clr;     // sweep counter back to zero
    logic cnt_inc;     // sweep counter step
    logic load_out;    // capture the result into the output register
  } dfc_cmd_t;

  typedef struct packed {
    logic last_acc;    // final beat of a set accepted this cycle
    logic walk_end;    // counter at last histogram entry
    logic clr_end;     // counter at last entry of the clearing pass
    logic walk_busy;   // walk pipeline still holds entries
    logic out_busy;    // output register holds a beat not yet taken
  } dfc_status_t;

endpackage

// ===== hdl/dfc_ctrl.sv =====
// Controller state machine for the distinct-frequency checker.
// Drives dfc_cmd_t from dfc_status_t; depends on dfc_pkg.
module dfc_ctrl
  import dfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dfc_status_t st,
  output dfc_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_LOAD  = 5'b00010,
    S_FIN   = 5'b00100,
    S_WALK  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (st.clr_end) state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_en = 1'b1;
        if (st.last_acc) state_next = S_FIN;
      end
      S_FIN: begin
        // last beat's histogram write lands this cycle
        cmd.cnt_clr    = 1'b1;
        cmd.walk_start = 1'b1;
        state_next     = S_WALK;
      end
      S_WALK: begin
        cmd.walk_rd = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (st.walk_end) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (!st.walk_busy && !st.out_busy) begin
          cmd.load_out = 1'b1;
          cmd.cnt_clr  = 1'b1;
          state_next   = S_CLEAR;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// ===== hdl/dfc_dp.sv =====
// Datapath for the distinct-frequency checker: histogram and seen-count
// memories, update and walk pipelines, output register. Depends on dfc_pkg.
module dfc_dp
  import dfc_pkg::*;
#(
  parameter int VALUE_BITS = 11,
  parameter int MAX_COUNT  = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic signed [10:0] value,
  input  logic               last,
  input  logic               result_ready,
  output logic               result_valid,
  output logic               all_distinct,
  output logic               overflow,
  input  dfc_cmd_t           cmd,
  output dfc_status_t        st
);

  localparam int HIST_DEPTH = 1 << VALUE_BITS;
  localparam int CW    = $clog2(MAX_COUNT + 1);
  localparam int SW    = $clog2(MAX_COUNT);
  localparam int TW    = $clog2(MAX_COUNT + 2);
  localparam int CLR_N = (HIST_DEPTH > MAX_COUNT) ? HIST_DEPTH : MAX_COUNT;
  localparam int CNT_W = $clog2(CLR_N);
  localparam int EW    = VALUE_BITS + 11;

  logic [CW-1:0] hist_mem [HIST_DEPTH];
  logic          seen_mem [MAX_COUNT];

  logic [CW-1:0]         hist_q;
  logic                  seen_q;
  logic [CNT_W-1:0]      cnt;
  logic                  s1_v;
  logic [VALUE_BITS-1:0] s1_addr;
  logic                  fwd_v;
  logic [VALUE_BITS-1:0] fwd_addr;
  logic [CW-1:0]         fwd_data;
  logic                  wa_v;
  logic                  wb_v;
  logic [CW-1:0]         wb_cnt;
  logic                  prev_v;
  logic [CW-1:0]         prev_cnt;
  logic                  distinct;
  logic [TW-1:0]         total;

  logic                  accept;
  logic [EW-1:0]         value_ext;
  logic [VALUE_BITS-1:0] in_addr;
  logic [VALUE_BITS-1:0] hist_rd_addr;
  logic [CW-1:0]         hist_cur;
  logic [CW-1:0]         hist_inc;
  logic                  cnt_in_hist;
  logic                  cnt_in_seen;
  logic                  hist_we;
  logic [VALUE_BITS-1:0] hist_wr_addr;
  logic [CW-1:0]         hist_wr_data;
  logic                  nz;
  logic [SW-1:0]         seen_rd_addr;
  logic                  seen_we;
  logic [SW-1:0]         seen_wr_addr;
  logic                  dup;

  assign accept    = item_valid & cmd.load_en;
  assign value_ext = EW'(value);
  assign in_addr   = value_ext[VALUE_BITS-1:0];

  assign hist_rd_addr = cmd.walk_rd ? cnt[VALUE_BITS-1:0] : in_addr;

  // write committed at the edge of this beat's read is not in hist_q yet
  assign hist_cur = (fwd_v && (fwd_addr == s1_addr)) ? fwd_data : hist_q;
  assign hist_inc = (hist_cur == CW'(MAX_COUNT)) ? hist_cur : hist_cur + 1'b1;

  assign cnt_in_hist = {1'b0, cnt} < (CNT_W + 1)'(HIST_DEPTH);
  assign cnt_in_seen = {1'b0, cnt} < (CNT_W + 1)'(MAX_COUNT);

  assign hist_we      = s1_v | (cmd.clear_wr & cnt_in_hist);
  assign hist_wr_addr = s1_v ? s1_addr : cnt[VALUE_BITS-1:0];
  assign hist_wr_data = s1_v ? hist_inc : '0;

  assign nz           = wa_v && (hist_q != '0);
  assign seen_rd_addr = SW'(hist_q - 1'b1);

  // back-to-back equal counts: the earlier mark is not in seen_q yet
  assign dup = wb_v && (seen_q || (prev_v && (prev_cnt == wb_cnt)));

  assign seen_we      = wb_v | (cmd.clear_wr & cnt_in_seen);
  assign seen_wr_addr = wb_v ? SW'(wb_cnt - 1'b1) : cnt[SW-1:0];

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_wr_addr] <= hist_wr_data;
    hist_q <= hist_mem[hist_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (seen_we) seen_mem[seen_wr_addr] <= wb_v;
    seen_q <= seen_mem[seen_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      s1_v         <= 1'b0;
      fwd_v        <= 1'b0;
      wa_v         <= 1'b0;
      wb_v         <= 1'b0;
      prev_v       <= 1'b0;
      total        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
      s1_v   <= accept;
      fwd_v  <= s1_v;
      wa_v   <= cmd.walk_rd;
      wb_v   <= nz;
      prev_v <= wb_v;
      if (cmd.clear_wr) begin
        total <= '0;
      end else if (accept && (total != TW'(MAX_COUNT + 1))) begin
        total <= total + 1'b1;
      end
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr  <= in_addr;
    fwd_addr <= s1_addr;
    fwd_data <= hist_inc;
    wb_cnt   <= hist_q;
    prev_cnt <= wb_cnt;
    if (cmd.walk_start) begin
      distinct <= 1'b1;
    end else if (dup) begin
      distinct <= 1'b0;
    end
    if (cmd.load_out) begin
      all_distinct <= distinct;
      overflow     <= total > TW'(MAX_COUNT);
    end
  end

  always_comb begin
    st.last_acc  = accept & last;
    st.walk_end  = cnt == CNT_W'(HIST_DEPTH - 1);
    st.clr_end   = cnt == CNT_W'(CLR_N - 1);
    st.walk_busy = wa_v | wb_v;
    st.out_busy  = result_valid & ~result_ready;
  end

endmodule

// ===== hdl/distinct_frequency_checker.sv =====
// Distinct-frequency checker, top level.
// Joins dfc_ctrl and dfc_dp; depends on dfc_pkg.
//
// Takes one signed value per beat, one beat per cycle, until the beat marked
// last. The set is counted in a 2^VALUE_BITS-entry histogram memory with one
// read-modify-write per beat; counts stop at MAX_COUNT. After the last beat
// the block walks the histogram, one entry per cycle through a two-stage
// memory pipeline, marking each nonzero count in a MAX_COUNT-entry bitmap;
// once the walk pipeline drains and the output register is free, the result
// beat is loaded. It gives all_distinct and overflow (set held more than
// MAX_COUNT elements). Then a clearing pass of max(2^VALUE_BITS, MAX_COUNT)
// entries zeroes both memories; the same pass runs after reset. No input beat
// is taken from the last beat of a set until the clearing pass ends. A
// finished result waits in an output register while the next set loads.
module distinct_frequency_checker
  import dfc_pkg::*;
#(
  parameter int VALUE_BITS = 11,
  parameter int MAX_COUNT  = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic signed [10:0] value,
  input  logic               last,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               all_distinct,
  output logic               overflow
);

  dfc_cmd_t    cmd;
  dfc_status_t st;

  assign item_ready = cmd.load_en;

  dfc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  dfc_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_COUNT  (MAX_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .value        (value),
    .last         (last),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .all_distinct (all_distinct),
    .overflow     (overflow),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

// ===== tb/testbench.sv =====
// Testbench for distinct_frequency_checker: directed stimulus table, then random sets.
// Expected verdicts come from a histogram predictor kept in this file.
// Depends on the RTL in hdl/ (dfc_pkg, distinct_frequency_checker).
`timescale 1ns / 1ps

module testbench;

  localparam int VALUE_BITS   = 11;
  localparam int MAX_COUNT    = 1024;
  localparam int HIST_DEPTH   = 1 << VALUE_BITS;
  localparam int DRAIN_CYCLES = 2 * HIST_DEPTH + 200;
  localparam int RAND_ITEMS   = 400;
  localparam int RAND_SETS    = 40;

  localparam logic signed [10:0] VAL_MIN = -11'sd1024;
  localparam logic signed [10:0] VAL_MAX = 11'sd1023;

  typedef struct packed {
    logic all_distinct;
    logic overflow;
  } verdict_t;

  // one row sends v reps times; last only on the final rep
  typedef struct packed {
    logic signed [10:0] v;
    logic               l;
    logic [11:0]        reps;
    logic               typed;
    logic               ad;
    logic               ov;
  } dir_row_t;

  localparam int DIR_ROWS = 15;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_ready;
  logic signed [10:0] value        = '0;
  logic               last         = 1'b0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic               all_distinct;
  logic               overflow;

  distinct_frequency_checker #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_COUNT (MAX_COUNT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .value       (value),
    .last        (last),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .all_distinct(all_distinct),
    .overflow    (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

  int          err_count = 0;
  verdict_t    pending_verdicts[$];
  int unsigned hist_counts[HIST_DEPTH];
  int unsigned set_total = 0;
  logic signed [10:0] set_vals[$];
  bit          quiet_sender = 1'b0;
  bit          quiet_sink   = 1'b0;
  int          stall_left   = 0;
  verdict_t    want;
  dir_row_t    dir_rows[DIR_ROWS];

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    err_count++;
  endtask

  // histogram update per beat; on the last beat, walk the counts and clear
  task automatic tally_beat(input logic signed [10:0] v, input logic l,
                            output logic done, output verdict_t verdict);
    logic [31:0] ext;
    int unsigned idx;
    int unsigned c;
    bit          seen[MAX_COUNT];
    int          i;
    ext = {{21{v[10]}}, v};
    idx = ext & (HIST_DEPTH - 1);
    if (hist_counts[idx] < MAX_COUNT) hist_counts[idx]++;
    if (set_total < MAX_COUNT + 1) set_total++;
    done    = l;
    verdict = '{all_distinct: 1'b1, overflow: 1'b0};
    if (l) begin
      for (i = 0; i < MAX_COUNT; i++) seen[i] = 1'b0;
      for (i = 0; i < HIST_DEPTH; i++) begin
        c = hist_counts[i];
        if (c != 0) begin
          if (seen[c - 1]) verdict.all_distinct = 1'b0;
          seen[c - 1] = 1'b1;
        end
        hist_counts[i] = 0;
      end
      verdict.overflow = (set_total > MAX_COUNT);
      set_total = 0;
    end
  endtask

  function automatic int pick_gap(input bit quiet, input int long_max);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, long_max);
  endfunction

  function automatic logic signed [10:0] pick_value();
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(0, 15) == 0) return r[0] ? VAL_MIN : VAL_MAX;
    return r[10:0];
  endfunction

  task automatic send_beat(input logic signed [10:0] v, input logic l,
                           input logic typed, input verdict_t typed_v);
    logic     done;
    verdict_t vd;
    int       gap;
    item_valid <= 1'b1;
    value      <= v;
    last       <= l;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    tally_beat(v, l, done, vd);
    if (done) pending_verdicts.push_back(typed ? typed_v : vd);
    gap = pick_gap(quiet_sender, 40);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // random set shapes: distinct counts (sometimes broken), small pools, wide spread, long runs
  task automatic build_set();
    int mode;
    int k;
    int n;
    int i;
    int j;
    bit dup;
    logic signed [10:0] cand;
    logic signed [10:0] tmp;
    logic signed [10:0] pool[$];
    set_vals.delete();
    mode = $urandom_range(0, 29);
    if (mode < 12) begin
      k = $urandom_range(1, 5);
      while (pool.size() < k) begin
        cand = pick_value();
        dup  = 1'b0;
        for (i = 0; i < pool.size(); i++) if (pool[i] == cand) dup = 1'b1;
        if (!dup) pool.push_back(cand);
      end
      for (i = 0; i < k; i++) repeat (i + 1) set_vals.push_back(pool[i]);
      // count 1 becomes 2, colliding with the second value
      if (k >= 2 && $urandom_range(0, 3) == 0) set_vals.push_back(pool[0]);
    end else begin
      if (mode < 22) begin
        k = $urandom_range(1, 4);
        n = $urandom_range(1, 12);
      end else if (mode < 29) begin
        k = 0;
        n = $urandom_range(1, 16);
      end else begin
        k = $urandom_range(1, 6);
        n = $urandom_range(30, 200);
      end
      for (i = 0; i < k; i++) pool.push_back(pick_value());
      for (i = 0; i < n; i++)
        set_vals.push_back(k == 0 ? pick_value() : pool[$urandom_range(0, k - 1)]);
    end
    for (i = set_vals.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = set_vals[i];
      set_vals[i] = set_vals[j];
      set_vals[j] = tmp;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result beat with nothing pending");
        end else begin
          want = pending_verdicts.pop_front();
          if (all_distinct !== want.all_distinct)
            report_mismatch($sformatf("all_distinct got %b want %b",
                                      all_distinct, want.all_distinct));
          if (overflow !== want.overflow)
            report_mismatch($sformatf("overflow got %b want %b",
                                      overflow, want.overflow));
        end
      end
      if ($urandom_range(0, 1999) == 0) quiet_sink = !quiet_sink;
      if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left <= pick_gap(quiet_sink, 60);
      end
    end
  end

  initial begin
    int r;
    int i;
    int rnd_items;
    int rnd_sets;
    dir_rows = '{
      '{VAL_MIN,        1'b1, 12'd1,    1'b1, 1'b1, 1'b0},  // single element, min
      '{VAL_MAX,        1'b1, 12'd1,    1'b1, 1'b1, 1'b0},  // single element, max
      '{11'sd0,         1'b1, 12'd1,    1'b1, 1'b1, 1'b0},
      '{-11'sd1,        1'b0, 12'd2,    1'b0, 1'b0, 1'b0},
      '{11'sd5,         1'b1, 12'd1,    1'b1, 1'b1, 1'b0},  // counts 2,1
      '{11'sd3,         1'b0, 12'd1,    1'b0, 1'b0, 1'b0},
      '{11'sd7,         1'b1, 12'd1,    1'b1, 1'b0, 1'b0},  // counts 1,1
      '{VAL_MIN,        1'b0, 12'd1,    1'b0, 1'b0, 1'b0},
      '{VAL_MAX,        1'b0, 12'd2,    1'b0, 1'b0, 1'b0},
      '{-11'sd1,        1'b0, 12'd3,    1'b0, 1'b0, 1'b0},
      '{11'sd1,         1'b1, 12'd1,    1'b0, 1'b0, 1'b0},
      '{11'sd5,         1'b0, 12'd1025, 1'b0, 1'b0, 1'b0},
      '{11'sd5,         1'b1, 12'd1,    1'b1, 1'b1, 1'b1},  // count and total saturate
      '{11'sd2,         1'b0, 12'd1,    1'b0, 1'b0, 1'b0},
      '{-11'sd2,        1'b1, 12'd3,    1'b0, 1'b0, 1'b0}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < DIR_ROWS; r++)
      for (i = 0; i < dir_rows[r].reps; i++)
        send_beat(dir_rows[r].v, dir_rows[r].l && (i == dir_rows[r].reps - 1),
                  dir_rows[r].typed, '{dir_rows[r].ad, dir_rows[r].ov});

    rnd_items = 0;
    rnd_sets  = 0;
    while (rnd_items < RAND_ITEMS || rnd_sets < RAND_SETS) begin
      build_set();
      quiet_sender = ($urandom_range(0, 4) == 0);
      for (i = 0; i < set_vals.size(); i++)
        send_beat(set_vals[i], i == set_vals.size() - 1, 1'b0, '0);
      rnd_items += set_vals.size();
      rnd_sets++;
    end
    item_valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== distinct_frequency_checker.f =====
hdl/dfc_pkg.sv
hdl/dfc_ctrl.sv
hdl/dfc_dp.sv
hdl/distinct_frequency_checker.sv
tb/testbench.sv
